[rtl/core/tlv_record_deframer_unit_defines.svh]
`ifndef TLV_RECORD_DEFRAMER_UNIT_DEFINES_SVH
`define TLV_RECORD_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, reset held off
`define TLVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset held off
`define TLVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tlvd_pkg.sv]
package tlvd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned POS_W        = 17;
  localparam int unsigned HBS_W        = 3;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned EV_W         = 3;
  localparam int unsigned OUT_DATA_W   = 56;

  localparam logic [EV_W-1:0] EV_HDR_BYTE = 3'd0;
  localparam logic [EV_W-1:0] EV_HDR_DONE = 3'd1;
  localparam logic [EV_W-1:0] EV_VAL_BYTE = 3'd2;
  localparam logic [EV_W-1:0] EV_TRUNC    = 3'd3;
  localparam logic [EV_W-1:0] EV_PAST_END = 3'd4;
  localparam logic [EV_W-1:0] EV_RESTART  = 3'd5;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic [15:0] value_offset;
    logic [7:0]  value_byte;
    logic [15:0] record_length;
    logic [15:0] record_type;
  } out_data_t;

endpackage

[rtl/core/tlv_record_deframer_unit.sv]
// TLV record deframer. Takes one buffer byte (in_tuser = 0) or a restart
// (in_tuser = 1) per transfer and returns exactly one result per transfer:
// a 4-byte header of big-endian 16-bit type and 16-bit length, then that
// many value bytes, each byte classified by out_tuser (0 header byte,
// 1 header complete, 2 value byte, 3 truncated, 4 past end, 5 restarted).
// Bounds are checked against buffer_length from the cfg port; the user
// must write it only while no transfer is outstanding, which the block
// does not enforce. Truncation is sticky until a restart. Each transfer
// is decoded when taken and its result appears in the next cycle from the
// output register, so the block sustains one transfer per clock while
// out_tready is high; the limit is the single state update per byte.
module tlv_record_deframer_unit
  import tlvd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEN_W-1:0]      cfg_data,      // buffer_length
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,      // [7:0] data_byte
  input  logic [0:0]            in_tuser,      // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,     // [15:0] record_type, [31:16] record_length,
                                               // [39:32] value_byte, [55:40] value_offset
  output logic [EV_W-1:0]       out_tuser,     // [2:0] event_code
  output logic                  out_tlast      // record_last
);

  logic [LEN_W-1:0] buf_len_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [HBS_W-1:0] hbs_r, hbs_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] vbs_r, vbs_nxt;
  logic             trunc_r, trunc_nxt;

  logic             out_valid_r;
  out_data_t        out_data_r, out_data_nxt;
  logic [EV_W-1:0]  out_ev_r, out_ev_nxt;
  logic             out_last_r, out_last_nxt;

  logic             acc;
  logic [LEN_W-1:0] vbs_inc;
  logic [POS_W:0]   buf_ext;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

  assign vbs_inc = vbs_r + LEN_W'(1);
  assign buf_ext = (POS_W+1)'(buf_len_r);

  always_comb begin
    pos_nxt      = pos_r;
    hbs_nxt      = hbs_r;
    type_nxt     = type_r;
    len_nxt      = len_r;
    vbs_nxt      = vbs_r;
    trunc_nxt    = trunc_r;
    out_ev_nxt   = EV_TRUNC;
    out_last_nxt = 1'b0;
    out_data_nxt = '0;
    if (in_tuser[0] == KIND_RESTART) begin
      pos_nxt    = '0;
      hbs_nxt    = '0;
      type_nxt   = '0;
      len_nxt    = '0;
      vbs_nxt    = '0;
      trunc_nxt  = 1'b0;
      out_ev_nxt = EV_RESTART;
    end else if (trunc_r) begin
      out_ev_nxt = EV_TRUNC;
    end else if ({1'b0, pos_r} >= buf_ext) begin
      out_ev_nxt = EV_PAST_END;
    end else if (hbs_r != HBS_W'(HEADER_BYTES)) begin
      if ((hbs_r == '0) && (({1'b0, pos_r} + (POS_W+1)'(HEADER_BYTES)) > buf_ext)) begin
        trunc_nxt  = 1'b1;
        out_ev_nxt = EV_TRUNC;
      end else begin
        case (hbs_r[1:0])
          2'd0:    type_nxt = {in_tdata, 8'h00};
          2'd1:    type_nxt = {type_r[15:8], in_tdata};
          2'd2:    len_nxt  = {in_tdata, 8'h00};
          default: len_nxt  = {len_r[15:8], in_tdata};
        endcase
        hbs_nxt = hbs_r + HBS_W'(1);
        pos_nxt = pos_r + POS_W'(1);
        if (hbs_r != HBS_W'(HEADER_BYTES - 1)) begin
          out_ev_nxt = EV_HDR_BYTE;
        end else if (({1'b0, pos_nxt} + (POS_W+1)'(len_nxt)) > buf_ext) begin
          trunc_nxt  = 1'b1;
          out_ev_nxt = EV_TRUNC;
        end else begin
          vbs_nxt    = '0;
          out_ev_nxt = EV_HDR_DONE;
          if (len_nxt == '0) begin
            hbs_nxt      = '0;
            out_last_nxt = 1'b1;
          end
        end
      end
    end else begin
      pos_nxt                   = pos_r + POS_W'(1);
      out_ev_nxt                = EV_VAL_BYTE;
      out_data_nxt.value_byte   = in_tdata;
      out_data_nxt.value_offset = vbs_r;
      if ((vbs_inc >= len_r) || (vbs_inc == '0)) begin
        out_last_nxt = 1'b1;
        hbs_nxt      = '0;
        vbs_nxt      = '0;
      end else begin
        vbs_nxt = vbs_inc;
      end
    end
    out_data_nxt.record_type   = type_nxt;
    out_data_nxt.record_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r   <= '0;
      pos_r       <= '0;
      hbs_r       <= '0;
      type_r      <= '0;
      len_r       <= '0;
      vbs_r       <= '0;
      trunc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        buf_len_r <= cfg_data;
      end
      if (acc) begin
        pos_r       <= pos_nxt;
        hbs_r       <= hbs_nxt;
        type_r      <= type_nxt;
        len_r       <= len_nxt;
        vbs_r       <= vbs_nxt;
        trunc_r     <= trunc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
      out_ev_r   <= out_ev_nxt;
      out_last_r <= out_last_nxt;
    end
  end

endmodule

[rtl/core/tlvd_checker.sv]
`include "tlv_record_deframer_unit_defines.svh"

module tlvd_checker
  import tlvd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [EV_W-1:0]       out_tuser,
  input logic                  out_tlast
);

  `TLVD_ASSERT_NEXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid, "transfer gave no result")
  `TLVD_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready, "input held off with output empty")
  `TLVD_ASSERT_NOW(a_restart_clean, clk, rst_n, out_tvalid && (out_tuser == EV_RESTART), (out_tdata == '0) && !out_tlast, "restart result not cleared")
  `TLVD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

endmodule

bind tlv_record_deframer_unit tlvd_checker u_tlvd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/sv/tlv_record_deframer_unit_test.sv]
module tlv_record_deframer_unit_test;
  import tlvd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [EV_W-1:0] code;
    logic [15:0]     rtype;
    logic [15:0]     rlen;
    logic [7:0]      vbyte;
    logic [15:0]     voff;
    logic            last;
  } tlv_event_t;

  class tlv_event_scoreboard;
    tlv_event_t  pending_events[$];
    logic [15:0] buf_len;
    logic [16:0] rd_pos;
    logic [2:0]  hdr_seen;
    logic [15:0] rec_type;
    logic [15:0] rec_len;
    logic [15:0] val_seen;
    bit          truncated;
    int          fails;
    int          checked;
    int          code_count[6];

    function new();
      buf_len = '0;
      clear_parse();
    endfunction

    function void clear_parse();
      rd_pos    = '0;
      hdr_seen  = '0;
      rec_type  = '0;
      rec_len   = '0;
      val_seen  = '0;
      truncated = 1'b0;
    endfunction

    function void set_buffer_length(logic [15:0] v);
      buf_len = v;
    endfunction

    function void flag(string msg);
      fails++;
      if (fails <= 10) $display("mismatch: %s", msg);
    endfunction

    function void take_input(logic kind, logic [7:0] b);
      tlv_event_t  ev;
      logic [15:0] off;
      ev = '0;
      if (kind == KIND_RESTART) begin
        clear_parse();
        ev.code = EV_RESTART;
      end else if (truncated) begin
        ev.code = EV_TRUNC;
      end else if (rd_pos >= {1'b0, buf_len}) begin
        ev.code = EV_PAST_END;
      end else if (hdr_seen < HEADER_BYTES) begin
        if (hdr_seen == 0 && 32'(rd_pos) + HEADER_BYTES > 32'(buf_len)) begin
          truncated = 1'b1;
          ev.code = EV_TRUNC;
        end else begin
          case (hdr_seen)
            3'd0: rec_type = {b, 8'h00};
            3'd1: rec_type = {rec_type[15:8], b};
            3'd2: rec_len = {b, 8'h00};
            default: rec_len = {rec_len[15:8], b};
          endcase
          hdr_seen = hdr_seen + 3'd1;
          rd_pos = rd_pos + 17'd1;
          if (hdr_seen < HEADER_BYTES) begin
            ev.code = EV_HDR_BYTE;
          end else if (32'(rd_pos) + 32'(rec_len) > 32'(buf_len)) begin
            truncated = 1'b1;
            ev.code = EV_TRUNC;
          end else begin
            val_seen = '0;
            ev.code = EV_HDR_DONE;
            if (rec_len == 16'd0) begin
              hdr_seen = '0;
              ev.last = 1'b1;
            end
          end
        end
      end else begin
        off = val_seen;
        val_seen = val_seen + 16'd1;
        rd_pos = rd_pos + 17'd1;
        if (val_seen >= rec_len || val_seen == 16'd0) begin
          ev.last = 1'b1;
          hdr_seen = '0;
          val_seen = '0;
        end
        ev.code = EV_VAL_BYTE;
        ev.vbyte = b;
        ev.voff = off;
      end
      ev.rtype = rec_type;
      ev.rlen = rec_len;
      pending_events.push_back(ev);
    endfunction

    function void check_result(logic [EV_W-1:0] code, logic [OUT_DATA_W-1:0] data,
                               logic last);
      out_data_t  d;
      tlv_event_t e;
      d = out_data_t'(data);
      if (pending_events.size() == 0) begin
        flag($sformatf("unexpected result code %0d type %h length %h", code,
                       d.record_type, d.record_length));
        return;
      end
      e = pending_events.pop_front();
      checked++;
      if (e.code < 6) code_count[e.code]++;
      if (code !== e.code || d.record_type !== e.rtype || d.record_length !== e.rlen ||
          d.value_byte !== e.vbyte || d.value_offset !== e.voff || last !== e.last) begin
        flag($sformatf({"result %0d: exp code %0d type %h len %h byte %h off %h last %b,",
                        " got code %0d type %h len %h byte %h off %h last %b"},
                       checked, e.code, e.rtype, e.rlen, e.vbyte, e.voff, e.last,
                       code, d.record_type, d.record_length, d.value_byte,
                       d.value_offset, last));
      end
    endfunction

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LEN_W-1:0]      cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [EV_W-1:0]       out_tuser;
  logic                  out_tlast;

  tlv_event_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int transfers_sent = 0;
  int cfg_writes = 0;
  int phase_goal;

  tlv_record_deframer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.take_input(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    transfers_sent++;
  endtask

  task automatic send_header(input logic [15:0] rtype, input logic [15:0] rlen);
    send_item(KIND_DATA, rtype[15:8]);
    send_item(KIND_DATA, rtype[7:0]);
    send_item(KIND_DATA, rlen[15:8]);
    send_item(KIND_DATA, rlen[7:0]);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_buffer_length(input logic [15:0] v);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_buffer_length(v);
    cfg_writes++;
  endtask

  task automatic run_buffer();
    logic [7:0]  frame_bytes[$];
    logic [15:0] rtype;
    int unsigned blen;
    int unsigned cap;
    int unsigned room;
    int unsigned rlen;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) blen = $urandom_range(48, 0);
    else if (r < 85) blen = $urandom_range(400, 49);
    else if (r < 92) blen = $urandom_range(3, 0);
    else blen = 65535 - $urandom_range(3, 0);
    cap = (blen < 96) ? blen : 96;
    while (frame_bytes.size() < cap) begin
      rtype = 16'($urandom);
      room = (blen > frame_bytes.size() + 4) ? blen - frame_bytes.size() - 4 : 0;
      r = $urandom_range(99);
      if (r < 60) rlen = $urandom_range(6, 1);
      else if (r < 75) rlen = 0;
      else if (r < 88) rlen = room;
      else if (r < 94) rlen = room + 1;
      else rlen = $urandom_range(65535, 0);
      frame_bytes.push_back(rtype[15:8]);
      frame_bytes.push_back(rtype[7:0]);
      frame_bytes.push_back(8'(rlen >> 8));
      frame_bytes.push_back(8'(rlen));
      while (rlen > 0 && frame_bytes.size() < cap + 4) begin
        frame_bytes.push_back(8'($urandom));
        rlen--;
      end
    end
    repeat ($urandom_range(3, 0)) frame_bytes.push_back(8'($urandom));
    write_buffer_length(16'(blen));
    if ($urandom_range(9) != 0) send_item(KIND_RESTART, 8'($urandom));
    foreach (frame_bytes[i]) begin
      if ($urandom_range(49) == 0) send_item(KIND_RESTART, 8'($urandom));
      send_item(KIND_DATA, frame_bytes[i]);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_DATA, 8'h5A);
    write_buffer_length(16'hFFFF);
    send_item(KIND_RESTART, 8'hFF);
    send_header(16'hFFFF, 16'h0001);
    send_item(KIND_DATA, 8'h80);
    write_buffer_length(16'd6);
    send_item(KIND_RESTART, 8'h00);
    send_header(16'h0102, 16'h0000);
    send_item(KIND_DATA, 8'h77);
    send_item(KIND_DATA, 8'h78);
    write_buffer_length(16'd20);
    send_item(KIND_RESTART, 8'h00);
    send_header(16'h1234, 16'hFFFF);
    send_item(KIND_RESTART, 8'h00);
    send_header(16'h0001, 16'h0008);
    send_item(KIND_DATA, 8'h11);
    write_buffer_length(16'd5);
    send_item(KIND_DATA, 8'h33);
    write_buffer_length(16'd0);

    write_buffer_length(16'hFFFF);
    hold_seq <= hold_seq + 1;
    send_item(KIND_RESTART, 8'h00);
    send_header(16'hBEEF, 16'd30);
    repeat (30) send_item(KIND_DATA, 8'($urandom));
    wait_results_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      phase_goal = transfers_sent + 320;
      while (transfers_sent < phase_goal) run_buffer();
    end

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.flag("results still outstanding at end of run");
    $display("checked %0d results from %0d transfers over %0d buffer length writes",
             sb.checked, transfers_sent, cfg_writes);
    $display("codes: header %0d, done %0d, value %0d, truncated %0d, past end %0d, restart %0d",
             sb.code_count[0], sb.code_count[1], sb.code_count[2], sb.code_count[3],
             sb.code_count[4], sb.code_count[5]);
    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
